/* src/pe2x_pkg.sv */
// shared types and constants for the palette expander with 2x pixel doubling
`default_nettype none
package pe2x_pkg;

	// field widths
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned COMP_W  = 8;
	localparam int unsigned SX_W    = 9;
	localparam int unsigned SY_W    = 8;
	localparam int unsigned ADDR_W  = 20;
	localparam int unsigned COLOR_W = 24;
	localparam int unsigned WRITES  = 4;

	// stream payload widths
	localparam int unsigned S_DATA_W = 64;
	localparam int unsigned M_DATA_W = 48;

	// palette depth
	localparam int unsigned PAL_DEPTH = 256;

	// job queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// opcodes carried in tuser
	typedef enum logic {
		OP_PAL_WRITE = 1'b0,
		OP_EXPAND    = 1'b1
	} opcode_t;

	// one expanded pixel: up to four writes around a base address
	typedef struct packed {
		logic [WRITES-1:0]  mask;
		logic               back;
		logic [COLOR_W-1:0] color;
		logic [ADDR_W-1:0]  base;
	} wr_job_t;

endpackage
`default_nettype wire

/* src/pe2x_front.sv */
// front end: accepts items, holds the palette, builds write jobs
`default_nettype none
module pe2x_front #(
	parameter int unsigned FRAME_WIDTH   = 1024,
	parameter int unsigned FRAME_HEIGHT  = 768,
	parameter int unsigned SOURCE_WIDTH  = 320,
	parameter int unsigned SOURCE_HEIGHT = 200
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [pe2x_pkg::S_DATA_W-1:0]       s_tdata,
	input  wire logic                                s_tuser,
	input  wire logic                                double_buffer,
	output logic                                     job_valid,
	input  wire logic                                job_ready,
	output pe2x_pkg::wr_job_t                        job
);

	localparam int unsigned CmpW  = 14;
	localparam int unsigned ProdW = 22;

	// unpacked input fields
	logic [pe2x_pkg::IDX_W-1:0]  write_entry;
	logic [pe2x_pkg::COMP_W-1:0] red_in, green_in, blue_in;
	logic [pe2x_pkg::IDX_W-1:0]  pixel_index;
	logic [pe2x_pkg::SX_W-1:0]   src_x;
	logic [pe2x_pkg::SY_W-1:0]   src_y;

	assign write_entry = s_tdata[7:0];
	assign red_in      = s_tdata[15:8];
	assign green_in    = s_tdata[23:16];
	assign blue_in     = s_tdata[31:24];
	assign pixel_index = s_tdata[39:32];
	assign src_x       = s_tdata[48:40];
	assign src_y       = s_tdata[56:49];

	// palette storage, valid bits stand in for the reset clear
	logic [pe2x_pkg::COLOR_W-1:0] pal_mem [pe2x_pkg::PAL_DEPTH];
	logic [pe2x_pkg::PAL_DEPTH-1:0] pal_vld_q;

	// stage 1 registers
	logic                         valid_s1;
	logic [pe2x_pkg::SX_W-1:0]    sx_s1;
	logic [pe2x_pkg::SY_W-1:0]    sy_s1;
	logic [pe2x_pkg::COLOR_W-1:0] rd_s1;
	logic                         hit_s1;
	logic                         back_s1;

	logic accept, is_pal, in_range, load_s1, s1_leave;
	logic [pe2x_pkg::WRITES-1:0] mask;

	// classify the transfer
	assign accept   = s_tvalid && s_tready;
	assign is_pal   = (pe2x_pkg::opcode_t'(s_tuser) == pe2x_pkg::OP_PAL_WRITE);
	assign in_range = (CmpW'(src_x) < CmpW'(SOURCE_WIDTH)) &&
	                  (CmpW'(src_y) < CmpW'(SOURCE_HEIGHT));
	assign load_s1  = accept && !is_pal && in_range;

	assign s1_leave = valid_s1 && (job_ready || (mask == '0));
	assign s_tready = !valid_s1 || s1_leave;

	// palette write port and registered read
	always_ff @(posedge clk) begin
		if (accept && is_pal) begin
			pal_mem[write_entry] <= {red_in, green_in, blue_in};
		end
		if (load_s1) begin
			rd_s1 <= pal_mem[pixel_index];
		end
	end

	// palette valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (accept && is_pal) begin
			pal_vld_q[write_entry] <= 1'b1;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (s1_leave) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (load_s1) begin
			sx_s1   <= src_x;
			sy_s1   <= src_y;
			hit_s1  <= pal_vld_q[pixel_index];
			back_s1 <= double_buffer;
		end
	end

	// target coordinates and which of the four writes land in the frame
	logic [CmpW-1:0] tx0, tx1, ty0, ty1;
	logic            x0_ok, x1_ok, y0_ok, y1_ok;

	assign tx0   = CmpW'({sx_s1, 1'b0});
	assign tx1   = CmpW'({sx_s1, 1'b1});
	assign ty0   = CmpW'({sy_s1, 1'b0});
	assign ty1   = CmpW'({sy_s1, 1'b1});
	assign x0_ok = tx0 < CmpW'(FRAME_WIDTH);
	assign x1_ok = tx1 < CmpW'(FRAME_WIDTH);
	assign y0_ok = ty0 < CmpW'(FRAME_HEIGHT);
	assign y1_ok = ty1 < CmpW'(FRAME_HEIGHT);
	assign mask  = {x1_ok && y1_ok, x0_ok && y1_ok, x1_ok && y0_ok, x0_ok && y0_ok};

	// base address of the top-left write
	logic [ProdW-1:0] row_base;
	assign row_base = ProdW'({sy_s1, 1'b0}) * ProdW'(FRAME_WIDTH) + ProdW'({sx_s1, 1'b0});

	assign job_valid  = valid_s1 && (mask != '0);
	assign job.mask   = mask;
	assign job.back   = back_s1;
	assign job.color  = hit_s1 ? rd_s1 : '0;
	assign job.base   = row_base[pe2x_pkg::ADDR_W-1:0];

endmodule
`default_nettype wire

/* src/pe2x_queue.sv */
// short job queue between front and back ends
`default_nettype none
module pe2x_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire pe2x_pkg::wr_job_t push_job,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output pe2x_pkg::wr_job_t      pop_job
);

	pe2x_pkg::wr_job_t entries [pe2x_pkg::Q_DEPTH];

	logic [pe2x_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [pe2x_pkg::Q_CNT_W-1:0] count_q;
	logic                         do_push, do_pop;

	assign push_ready = (count_q != pe2x_pkg::Q_CNT_W'(pe2x_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = entries[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/pe2x_back.sv */
// back end: walks the writes of each job, one write per cycle while m_tready does not stall
`default_nettype none
module pe2x_back #(
	parameter int unsigned FRAME_WIDTH = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          job_valid,
	output logic                               job_ready,
	input  wire pe2x_pkg::wr_job_t             job,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [pe2x_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                               m_tuser,
	output logic                               m_tlast
);

	localparam int unsigned AW = pe2x_pkg::ADDR_W;

	// job being worked on
	logic [pe2x_pkg::WRITES-1:0]  cur_mask_q;
	logic [AW-1:0]                cur_base_q;
	logic [pe2x_pkg::COLOR_W-1:0] cur_color_q;
	logic                         cur_back_q;

	// output register
	logic                         out_valid_q;
	logic [AW-1:0]                out_addr_q;
	logic [pe2x_pkg::COLOR_W-1:0] out_color_q;
	logic                         out_back_q;
	logic                         out_last_q;

	logic                        busy, emit, done, take;
	logic [pe2x_pkg::WRITES-1:0] pick, rest;
	logic                        step_x, step_y;
	logic [AW-1:0]               addr;

	// lowest pending write goes first
	always_comb begin
		priority if (cur_mask_q[0]) begin
			pick = 4'b0001;
		end else if (cur_mask_q[1]) begin
			pick = 4'b0010;
		end else if (cur_mask_q[2]) begin
			pick = 4'b0100;
		end else begin
			pick = 4'b1000;
		end
	end

	assign rest   = cur_mask_q & ~pick;
	assign step_x = pick[1] || pick[3];
	assign step_y = pick[2] || pick[3];
	assign addr   = cur_base_q + AW'(step_x) + (step_y ? AW'(FRAME_WIDTH) : '0);

	// handshake between job, walker and output register
	assign busy      = (cur_mask_q != '0);
	assign emit      = busy && (!out_valid_q || m_tready);
	assign done      = emit && (rest == '0);
	assign take      = !busy || done;
	assign job_ready = take;

	// walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q <= '0;
		end else if (take && job_valid) begin
			cur_mask_q <= job.mask;
		end else if (emit) begin
			cur_mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (take && job_valid) begin
			cur_base_q  <= job.base;
			cur_color_q <= job.color;
			cur_back_q  <= job.back;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q  <= addr;
			out_color_q <= cur_color_q;
			out_back_q  <= cur_back_q;
			out_last_q  <= (rest == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_color_q, out_addr_q};
	assign m_tuser  = out_back_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

/* src/palette_expand_2x_upscale.sv */
// Palette lookup with 2x pixel doubling, top level.
// Path: a pixel passes the front stage 1 register, the job queue, the back
// end walker and its output register. Throughput: one framebuffer write per
// cycle while m_tready is high; palette writes produce no framebuffer writes.
// Reset: asynchronous; palette valid bits clear at once, so every entry reads
// zero until written; buffer select resets to the front buffer.
`default_nettype none
module palette_expand_2x_upscale #(
	parameter int unsigned FRAME_WIDTH   = 1024,
	parameter int unsigned FRAME_HEIGHT  = 768,
	parameter int unsigned SOURCE_WIDTH  = 320,
	parameter int unsigned SOURCE_HEIGHT = 200
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// write_entry[7:0] red_in[15:8] green_in[23:16] blue_in[31:24]
	// pixel_index[39:32] src_x[48:40] src_y[56:49], zero above
	input  wire logic [63:0] s_tdata,
	// opcode
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// pixel_address[19:0] pixel_color[43:20], zero above
	output logic [47:0]      m_tdata,
	// target_back
	output logic             m_tuser,
	// last_write
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata
);

	logic double_buffer_q;

	logic              f_valid, f_ready, b_valid, b_ready;
	pe2x_pkg::wr_job_t f_job, b_job;

	// buffer select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_buffer_q <= 1'b0;
		end else if (cfg_we) begin
			double_buffer_q <= cfg_wdata;
		end
	end

	// front end
	pe2x_front #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.SOURCE_WIDTH (SOURCE_WIDTH),
		.SOURCE_HEIGHT(SOURCE_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.double_buffer(double_buffer_q),
		.job_valid    (f_valid),
		.job_ready    (f_ready),
		.job          (f_job)
	);

	// job queue
	pe2x_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_job  (f_job),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_job   (b_job)
	);

	// back end
	pe2x_back #(
		.FRAME_WIDTH(FRAME_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(b_valid),
		.job_ready(b_ready),
		.job      (b_job),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
